FILE: src/assert_macros.svh
// assertion macros used by the checker file eeg_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define EEG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed: %m");

// clocked assertion, checked during reset too
`define EEG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed: %m");

`endif

FILE: src/eeg_pkg.sv
// types, widths and helpers for the extended euclid gcd core
// no dependencies
package eeg_pkg;

  localparam int unsigned OperandBits   = 32;
  localparam int unsigned MagBits       = 31;
  localparam int unsigned CoefBits      = 32;
  localparam int unsigned DataBitsDflt  = 32;

  typedef logic [MagBits-1:0]  mag_t;
  typedef logic [CoefBits-1:0] coef_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // magnitude of a two's complement operand, most negative value saturates
  function automatic mag_t magnitude(input logic [OperandBits-1:0] v);
    logic [OperandBits-1:0] neg;
    neg = ~v + OperandBits'(1);
    if (!v[OperandBits-1]) begin
      magnitude = v[MagBits-1:0];
    end else if (neg[OperandBits-1]) begin
      magnitude = '1;
    end else begin
      magnitude = neg[MagBits-1:0];
    end
  endfunction

endpackage

FILE: src/eeg_if.sv
// channel interfaces for the extended euclid gcd core
// depends on eeg_pkg
interface eeg_in_if;
  logic valid;
  logic ready;
  logic signed [eeg_pkg::OperandBits-1:0] first_value;
  logic signed [eeg_pkg::OperandBits-1:0] second_value;
  modport source (output valid, output first_value, output second_value, input ready);
  modport sink (input valid, input first_value, input second_value, output ready);
endinterface

interface eeg_out_if;
  logic valid;
  logic ready;
  logic [eeg_pkg::MagBits-1:0] divisor;
  logic signed [eeg_pkg::CoefBits-1:0] coef_first;
  logic signed [eeg_pkg::CoefBits-1:0] coef_second;
  logic undefined;
  modport source (output valid, output divisor, output coef_first, output coef_second,
                  output undefined, input ready);
  modport sink (input valid, input divisor, input coef_first, input coef_second,
                input undefined, output ready);
endinterface

FILE: src/extended_euclid_gcd_core.sv
// extended euclid gcd core: gcd of two operand magnitudes with bezout coefficients
// input channel carries first_value and second_value, output channel carries divisor,
// coef_first, coef_second and undefined; valid/ready, a transaction on valid and ready
// each operand is replaced by its magnitude (most negative value saturates)
// one transaction in gives exactly one transaction out
// the core takes one operand pair at a time; in_i.ready is low while it works
// each quotient step is one pass through the shared bit-serial divider, then back to the check state
// the quotient step count is at most 46 for 31-bit magnitudes
// both operands zero skip the divider and go straight to the done state
// in_i.ready rises again in the cycle the result is registered
// step count is capped at 2 * DATA_BITS, beyond that undefined is reported
// results sit in an output register; a finished result waits there while the
// receiver stalls, and the core holds the next result until the register frees
// reset clears all control state; no transaction is in flight after reset
module extended_euclid_gcd_core #(
  parameter int unsigned DATA_BITS = eeg_pkg::DataBitsDflt
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  eeg_in_if.sink    in_i,
  eeg_out_if.source out_o
);

  localparam int unsigned Limit    = 2 * DATA_BITS;
  localparam int unsigned StepBits = $clog2(Limit + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_DIV, ST_DONE} state_e;

  state_e               state_q;
  logic [StepBits-1:0]  steps_q;
  logic                 undef_q;
  eeg_pkg::mag_t        old_r_q, r_q;
  eeg_pkg::coef_t       old_cb_q, cb_q, old_ca_q, ca_q;
  logic                 out_valid_q, out_undef_q;
  eeg_pkg::mag_t        out_div_q;
  eeg_pkg::coef_t       out_cf_q, out_cs_q;
  eeg_pkg::mag_t        mag_a, mag_b, rem;
  eeg_pkg::coef_t       prod_b, prod_a;
  eeg_pkg::div_status_t div_st;
  logic                 div_start, in_take, out_free;

  assign mag_a     = eeg_pkg::magnitude(in_i.first_value);
  assign mag_b     = eeg_pkg::magnitude(in_i.second_value);
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_take   = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign div_start = (state_q == ST_CHECK) && (r_q != '0) && (steps_q != StepBits'(Limit));

  eeg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (old_r_q),
    .divisor_i  (r_q),
    .coef_b_i   (cb_q),
    .coef_a_i   (ca_q),
    .status_o   (div_st),
    .rem_o      (rem),
    .prod_b_o   (prod_b),
    .prod_a_o   (prod_a)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      steps_q     <= '0;
      undef_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            steps_q <= '0;
            undef_q <= (mag_a == '0) && (mag_b == '0);
            state_q <= ((mag_a == '0) && (mag_b == '0)) ? ST_DONE : ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (r_q == '0) begin
            state_q <= ST_DONE;
          end else if (steps_q == StepBits'(Limit)) begin
            undef_q <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_st.done) begin
            steps_q <= steps_q + StepBits'(1);
            state_q <= ST_CHECK;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      old_r_q  <= mag_b;
      r_q      <= mag_a;
      old_cb_q <= eeg_pkg::CoefBits'(1);
      cb_q     <= '0;
      old_ca_q <= '0;
      ca_q     <= eeg_pkg::CoefBits'(1);
    end else if (state_q == ST_DIV && div_st.done) begin
      old_r_q  <= r_q;
      r_q      <= rem;
      old_cb_q <= cb_q;
      cb_q     <= old_cb_q - prod_b;
      old_ca_q <= ca_q;
      ca_q     <= old_ca_q - prod_a;
    end
    if (state_q == ST_DONE && out_free) begin
      out_undef_q <= undef_q;
      out_div_q   <= undef_q ? '0 : old_r_q;
      out_cf_q    <= undef_q ? '0 : old_ca_q;
      out_cs_q    <= undef_q ? '0 : old_cb_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.undefined   = out_undef_q;
  assign out_o.divisor     = out_div_q;
  assign out_o.coef_first  = out_cf_q;
  assign out_o.coef_second = out_cs_q;

endmodule

FILE: src/eeg_div.sv
// iterative restoring divider, one quotient bit per cycle
// also builds quotient times both coefficients by shift and add; depends on eeg_pkg
module eeg_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  eeg_pkg::mag_t        dividend_i,
  input  eeg_pkg::mag_t        divisor_i,
  input  eeg_pkg::coef_t       coef_b_i,
  input  eeg_pkg::coef_t       coef_a_i,
  output eeg_pkg::div_status_t status_o,
  output eeg_pkg::mag_t        rem_o,
  output eeg_pkg::coef_t       prod_b_o,
  output eeg_pkg::coef_t       prod_a_o
);

  localparam int unsigned CntBits = $clog2(eeg_pkg::MagBits);

  logic                 busy_q, done_q;
  logic [CntBits-1:0]   cnt_q;
  eeg_pkg::mag_t        rem_q, dvd_q, dsr_q;
  eeg_pkg::coef_t       cb_q, ca_q, pb_q, pa_q;
  logic [eeg_pkg::MagBits:0] trial, diff;
  logic                 qbit;

  assign trial = {rem_q, dvd_q[eeg_pkg::MagBits-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign qbit  = !diff[eeg_pkg::MagBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(eeg_pkg::MagBits - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      cb_q  <= coef_b_i;
      ca_q  <= coef_a_i;
      pb_q  <= '0;
      pa_q  <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[eeg_pkg::MagBits-1:0] : trial[eeg_pkg::MagBits-1:0];
      dvd_q <= {dvd_q[eeg_pkg::MagBits-2:0], 1'b0};
      pb_q  <= {pb_q[eeg_pkg::CoefBits-2:0], 1'b0} + (qbit ? cb_q : '0);
      pa_q  <= {pa_q[eeg_pkg::CoefBits-2:0], 1'b0} + (qbit ? ca_q : '0);
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o    = rem_q;
  assign prod_b_o = pb_q;
  assign prod_a_o = pa_q;

endmodule

FILE: src/eeg_checker.sv
// port-level checks for the extended euclid gcd core, attached by bind
// depends on eeg_pkg and assert_macros.svh
`include "assert_macros.svh"

module eeg_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 out_undefined_i,
  input eeg_pkg::mag_t        out_divisor_i,
  input eeg_pkg::coef_t       out_coef_first_i,
  input eeg_pkg::coef_t       out_coef_second_i
);

  `EEG_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `EEG_ASSERT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i)
  `EEG_ASSERT(a_undef_zero, clk_i, rst_ni, out_valid_i && out_undefined_i |-> out_divisor_i == '0 && out_coef_first_i == '0 && out_coef_second_i == '0)
  `EEG_ASSERT(a_gcd_nonzero, clk_i, rst_ni, out_valid_i && !out_undefined_i |-> out_divisor_i != '0)
  `EEG_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_i)

endmodule

bind extended_euclid_gcd_core eeg_checker u_eeg_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_undefined_i   (out_o.undefined),
  .out_divisor_i     (out_o.divisor),
  .out_coef_first_i  (out_o.coef_first),
  .out_coef_second_i (out_o.coef_second)
);

FILE: test/eeg_gcd_checker.sv
// checker for the extended euclid gcd core: predicts gcd and bezout coefficients
// per input transaction and compares each output transaction; depends on eeg_pkg, eeg_if
`timescale 1ns / 1ps
module eeg_gcd_checker #(
  parameter int unsigned DATA_BITS = eeg_pkg::DataBitsDflt
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  eeg_in_if.sink  in_mon,
  eeg_out_if.sink out_mon,
  output int      fail_count_o,
  output int      pending_o,
  output int      results_o
);

  typedef struct packed {
    eeg_pkg::mag_t  divisor;
    eeg_pkg::coef_t coef_first;
    eeg_pkg::coef_t coef_second;
    logic           undefined;
  } gcd_result_t;

  gcd_result_t expected_q[$];
  int fail_count = 0;
  int result_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_q.size();
  assign results_o    = result_count;

  function automatic logic [31:0] abs_sat(input logic [31:0] v);
    logic [31:0] m;
    m = v;
    if (v[31]) begin
      m = ~v + 32'd1;
      if (m > 32'h7fffffff) m = 32'h7fffffff;
    end
    return m;
  endfunction

  function automatic gcd_result_t predict_gcd(input logic [31:0] fv, input logic [31:0] sv);
    logic [63:0] a, b, old_r, r, q, t, old_cb, cb, old_ca, ca;
    int unsigned steps;
    gcd_result_t res;
    a = 64'(abs_sat(fv));
    b = 64'(abs_sat(sv));
    res = '0;
    if (a == 0 && b == 0) begin
      res.undefined = 1'b1;
      return res;
    end
    old_r = b; r = a;
    old_cb = 1; cb = 0;
    old_ca = 0; ca = 1;
    steps = 0;
    while (r != 0 && steps < 2 * DATA_BITS) begin
      q = old_r / r;
      t = old_r - q * r; old_r = r; r = t;
      t = old_cb - q * cb; old_cb = cb; cb = t;
      t = old_ca - q * ca; old_ca = ca; ca = t;
      steps++;
    end
    if (r != 0) begin
      res.undefined = 1'b1;
      return res;
    end
    res.divisor     = old_r[30:0];
    res.coef_first  = old_ca[31:0];
    res.coef_second = old_cb[31:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    gcd_result_t want;
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready)
        expected_q = {expected_q, predict_gcd(in_mon.first_value, in_mon.second_value)};
      if (out_mon.valid && out_mon.ready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", 32'(out_mon.divisor), 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.divisor !== want.divisor)
            report_mismatch("divisor", 32'(out_mon.divisor), 32'(want.divisor));
          if (out_mon.coef_first !== want.coef_first)
            report_mismatch("coef_first", out_mon.coef_first, want.coef_first);
          if (out_mon.coef_second !== want.coef_second)
            report_mismatch("coef_second", out_mon.coef_second, want.coef_second);
          if (out_mon.undefined !== want.undefined)
            report_mismatch("undefined", 32'(out_mon.undefined), 32'(want.undefined));
        end
      end
    end
  end
endmodule

FILE: test/extended_euclid_gcd_core_tb.sv
// testbench top for the extended euclid gcd core: directed and random operand pairs
// with random idling and a long receiver stall; depends on eeg_pkg, eeg_if, eeg_gcd_checker
`timescale 1ns / 1ps
module extended_euclid_gcd_core_tb;

  localparam int NumRandom = 400;
  localparam int CycleLimit = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int fail_count, pending, results;
  int cycles = 0;
  int sent = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  eeg_in_if  in_ch ();
  eeg_out_if out_ch ();

  extended_euclid_gcd_core dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  eeg_gcd_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_pair(input logic [31:0] fv, input logic [31:0] sv);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.first_value <= fv;
    in_ch.second_value <= sv;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 20);
      1: v = -$urandom_range(0, 20);
      2: v = $urandom_range(0, 65535);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // receiver: random stalls per transaction, plus one long hold-off
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 7);
      if (stall != 0 || hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  initial begin
    logic [31:0] fv, sv, common;
    in_ch.valid = 1'b0;
    in_ch.first_value = '0;
    in_ch.second_value = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_pair(0, 0);
    send_pair(0, 7);
    send_pair(9, 0);
    send_pair(32'h7fffffff, 32'h7fffffff);
    send_pair(32'h80000000, 32'h7fffffff);
    send_pair(32'h80000000, 32'h80000000);
    send_pair(32'h80000001, 5);
    send_pair(-12, 18);
    send_pair(240, -46);
    send_pair(1836311903, 1134903170);
    send_pair(1134903170, 1836311903);
    send_pair(-1, -1);
    send_pair(1, 32'h80000000);
    send_pair(32'h55555555, 32'haaaaaaaa);
    send_pair(17, 17);
    // long hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (4000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (6) send_pair(rand_operand(), rand_operand());
    join
    for (int i = 0; i < NumRandom; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        common = $urandom_range(1, 4096);
        fv = common * $urandom_range(0, 100000);
        sv = common * $urandom_range(0, 100000);
        if ($urandom_range(0, 1)) fv = -fv;
        if ($urandom_range(0, 1)) sv = -sv;
      end else begin
        fv = rand_operand();
        sv = rand_operand();
      end
      send_pair(fv, sv);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    $display("sent %0d operand pairs, checked %0d results", sent, results);
    $display("covered zero, saturated, fibonacci-worst and random common-factor operands");
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
